### sv/bfpa_pkg.sv
// Shared types, codes and defaults of the bucketed free-list page allocator.
package bfpa_pkg;

  // Default geometry handed to the top-level parameters.
  localparam int BUCKETS_DEF = 64;
  localparam int PAGES_DEF   = 4096;

  // Register indexes on the configuration port.
  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_BUCKET_SHIFT = 1'b1;

  // Register reset values.
  localparam logic [6:0] BUCKET_COUNT_RST = 7'd64;
  localparam logic [3:0] BUCKET_SHIFT_RST = 4'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Item modes.
  localparam logic MODE_FREE  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] page_number;
    logic [5:0]  start_bucket;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic [5:0]  bucket_used;
    logic        start_was_empty;
  } out_item_t;

  typedef struct packed {
    logic [6:0] bucket_count;
    logic [3:0] bucket_shift;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic head_step;
    logic next_step;
    logic fault_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_fault;
    logic slot_free;
    logic done_at_head;
  } sts_t;

endpackage

### sv/bfpa_cfg.sv
// Configuration register file with its APB-style access port.
module bfpa_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output bfpa_pkg::cfg_t  cfg
);
  import bfpa_pkg::*;

  logic [6:0] count_r;
  logic [3:0] shift_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= BUCKET_COUNT_RST;
      shift_r <= BUCKET_SHIFT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BUCKET_COUNT: count_r <= pwdata[6:0];
        REG_BUCKET_SHIFT: shift_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BUCKET_COUNT: prdata = {25'd0, count_r};
      REG_BUCKET_SHIFT: prdata = {28'd0, shift_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.bucket_count = count_r;
  assign cfg.bucket_shift = shift_r;

endmodule

### sv/bfpa_ctrl.sv
// Sequencing state machine of the page allocator.
module bfpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bfpa_pkg::sts_t  sts,
  output bfpa_pkg::cmd_t  cmd
);
  import bfpa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HEAD  = 2'd1;
  localparam logic [1:0] S_NEXT  = 2'd2;
  localparam logic [1:0] S_FAULT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.head_step  = 1'b0;
    cmd.next_step  = 1'b0;
    cmd.fault_step = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = sts.item_fault ? S_FAULT : S_HEAD;
        end
      end
      S_HEAD: begin
        // A step that ends the item waits for room in the result register.
        if (!sts.done_at_head || sts.slot_free) begin
          cmd.head_step = 1'b1;
          state_nxt     = sts.done_at_head ? S_IDLE : S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.slot_free) begin
          cmd.next_step = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FAULT: begin
        if (sts.slot_free) begin
          cmd.fault_step = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/bfpa_dpath.sv
// Datapath: bucket search, head and next tables, result register.
module bfpa_dpath #(
  parameter int BUCKETS = bfpa_pkg::BUCKETS_DEF,
  parameter int PAGES   = bfpa_pkg::PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfpa_pkg::cfg_t      cfg,
  input  bfpa_pkg::in_item_t  in_data,
  input  bfpa_pkg::cmd_t      cmd,
  output bfpa_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output bfpa_pkg::out_item_t out_data
);
  import bfpa_pkg::*;

  localparam int BIW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CNTW = ($clog2(BUCKETS + 1) > 7) ? $clog2(BUCKETS + 1) : 7;
  localparam int XW   = (CNTW > 12) ? CNTW : 12;
  localparam int PCW  = ($clog2(PAGES + 1) > 12) ? $clog2(PAGES + 1) : 12;

  // Tables: head page per bucket, link to the page below per page.
  logic [PW-1:0] head_mem [BUCKETS];
  logic [PW:0]   next_mem [PAGES];
  logic [BUCKETS-1:0] valid_r;
  logic [BUCKETS-1:0] valid_nxt;

  logic [PW-1:0]  head_rd_r;
  logic [PW:0]    next_rd_r;
  logic           mode_r;
  logic [PW-1:0]  page_r;
  logic [BIW-1:0] bkt_r;
  logic           se_r;
  logic [1:0]     flt_st_r;
  logic           flt_se_r;

  logic           out_valid_r;
  out_item_t      out_data_r;

  // Item classification and bucket search.
  logic [CNTW-1:0] cnt_ext;
  logic [CNTW-1:0] cnt_eff;
  logic [XW-1:0]   cnt_x;
  logic [XW-1:0]   start_x;
  logic [XW-1:0]   pb_x;
  logic [11:0]     push_bkt;
  logic            page_bad;
  logic            range_bad;
  logic            bad_start;
  logic [BUCKETS-1:0] in_mask;
  logic [BUCKETS-1:0] avail;
  logic [BUCKETS-1:0] upper;
  logic            hi_hit;
  logic            lo_hit;
  logic [BIW-1:0]  hi_idx;
  logic [BIW-1:0]  lo_idx;
  logic [BIW-1:0]  found;
  logic            start_valid;
  logic [BIW-1:0]  rd_addr;
  logic [1:0]      flt_st;
  logic            flt_se;
  logic            fault;
  logic            got_ok;
  logic            out_load;
  out_item_t       out_val;

  assign cnt_ext  = CNTW'(cfg.bucket_count);
  assign cnt_eff  = (cnt_ext > CNTW'(BUCKETS)) ? CNTW'(BUCKETS) : cnt_ext;
  assign cnt_x    = XW'(cnt_eff);
  assign start_x  = XW'(in_data.start_bucket);
  assign push_bkt = in_data.page_number >> cfg.bucket_shift;
  assign pb_x     = XW'(push_bkt);
  assign page_bad = PCW'(in_data.page_number) >= PCW'(PAGES);
  assign range_bad = page_bad || (pb_x >= cnt_x);
  assign bad_start = start_x >= cnt_x;

  always_comb begin
    for (int i = 0; i < BUCKETS; i++) begin
      in_mask[i] = XW'(i) < cnt_x;
      upper[i]   = XW'(i) >= start_x;
    end
  end

  assign avail = valid_r & in_mask;

  // Rotated priority encode: lowest live bucket at or above the start,
  // else lowest live bucket overall.
  always_comb begin
    hi_hit = 1'b0;
    lo_hit = 1'b0;
    hi_idx = '0;
    lo_idx = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (avail[i] && upper[i]) begin
        hi_hit = 1'b1;
        hi_idx = BIW'(i);
      end
      if (avail[i]) begin
        lo_hit = 1'b1;
        lo_idx = BIW'(i);
      end
    end
  end

  assign found       = hi_hit ? hi_idx : lo_idx;
  assign start_valid = (start_x < XW'(BUCKETS)) && valid_r[start_x[BIW-1:0]];
  assign rd_addr     = (in_data.mode == MODE_ALLOC) ? found : pb_x[BIW-1:0];

  always_comb begin
    flt_st = ST_OK;
    flt_se = 1'b0;
    fault  = 1'b0;
    if (in_data.mode == MODE_FREE) begin
      if (range_bad) begin
        flt_st = ST_RANGE;
        fault  = 1'b1;
      end
    end else if (bad_start) begin
      flt_st = ST_BAD_START;
      fault  = 1'b1;
    end else if (!lo_hit) begin
      flt_st = ST_EMPTY;
      flt_se = 1'b1;
      fault  = 1'b1;
    end
  end

  // Item registers, captured at the input beat.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_data.mode;
      page_r   <= PW'(in_data.page_number);
      bkt_r    <= rd_addr;
      se_r     <= !start_valid;
      flt_st_r <= flt_st;
      flt_se_r <= flt_se;
    end
  end

  assign got_ok = PCW'(head_rd_r) < PCW'(PAGES);

  // Head table: read at the input beat, written on push or relink.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      head_rd_r <= head_mem[rd_addr];
    end
    if (cmd.head_step && (mode_r == MODE_FREE)) begin
      head_mem[bkt_r] <= page_r;
    end else if (cmd.next_step) begin
      head_mem[bkt_r] <= next_rd_r[PW-1:0];
    end
  end

  // Next table: written on push, read while popping.
  always_ff @(posedge clk) begin
    if (cmd.head_step && (mode_r == MODE_FREE)) begin
      next_mem[page_r] <= {valid_r[bkt_r], head_rd_r};
    end
    if (cmd.head_step && (mode_r == MODE_ALLOC) && got_ok) begin
      next_rd_r <= next_mem[head_rd_r];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.head_step) begin
      if (mode_r == MODE_FREE) begin
        valid_nxt[bkt_r] = 1'b1;
      end else if (!got_ok) begin
        valid_nxt[bkt_r] = 1'b0;
      end
    end else if (cmd.next_step) begin
      valid_nxt[bkt_r] = next_rd_r[PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result register.
  assign out_load = (cmd.head_step && sts.done_at_head) || cmd.next_step || cmd.fault_step;

  always_comb begin
    if (cmd.fault_step) begin
      out_val.status          = flt_st_r;
      out_val.granted_page    = '0;
      out_val.bucket_used     = '0;
      out_val.start_was_empty = flt_se_r;
    end else if (mode_r == MODE_FREE) begin
      out_val.status          = ST_OK;
      out_val.granted_page    = '0;
      out_val.bucket_used     = 6'(bkt_r);
      out_val.start_was_empty = 1'b0;
    end else begin
      out_val.status          = ST_OK;
      out_val.granted_page    = 12'(head_rd_r);
      out_val.bucket_used     = 6'(bkt_r);
      out_val.start_was_empty = se_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign sts.item_fault   = fault;
  assign sts.slot_free    = !out_valid_r || out_ready;
  assign sts.done_at_head = (mode_r == MODE_FREE) || !got_ok;

endmodule

### sv/bucketed_free_list_page_allocator_unit.sv
// Top level of the bucketed free-list page allocator.
//
// Free pages sit in per-bucket last-in-first-out lists: a head table holds
// the top page of each bucket and a next table links every page to the one
// below it. A free beat (mode 0) pushes page_number onto bucket
// page_number >> bucket_shift; an allocate beat (mode 1) scans the buckets
// circularly from start_bucket, modulo bucket_count (saturated to BUCKETS),
// and pops the first non-empty one. Every input beat gives exactly one result
// beat with a status (ok, no free page, bad start bucket, page out of range),
// the granted page, the bucket used and whether the start bucket was empty.
// Items are handled one at a time. The bucket search and the head-table
// read happen at the input beat; a free then ends at its head step, a
// rejected item at a fault step, and the pop of an allocate needs one more
// registered read of the next table. A result waiting in the output register
// holds the final step of the following item until the beat is taken. Both
// tables are plain memories; only the per-bucket valid bits are cleared by
// reset, so no clearing pass is needed. Write bucket_count (byte address 0)
// and bucket_shift (byte address 4) only while the block is idle.
module bucketed_free_list_page_allocator_unit #(
  parameter int BUCKETS = bfpa_pkg::BUCKETS_DEF,
  parameter int PAGES   = bfpa_pkg::PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  bfpa_pkg::in_item_t  in_data,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output bfpa_pkg::out_item_t out_data,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bfpa_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register file: bucket_count and bucket_shift.
  bfpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: accept, head step, next step or fault step.
  bfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, bucket search and result register.
  bfpa_dpath #(
    .BUCKETS (BUCKETS),
    .PAGES   (PAGES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
